// ----- rtl/rlw_pkg.sv -----
// ----------------------------------------------------------------------------
// rlw_pkg
// Shared constants, field widths and register indexes for the radial lens
// warp map.
// ----------------------------------------------------------------------------
package rlw_pkg;

  localparam int FRAC_BITS = 8;
  localparam int MAX_DIM   = 4096;

  localparam int PIX_W  = 12;   // pixel coordinate
  localparam int COEF_W = 20;   // k1, k2 (signed Q3.16)
  localparam int CTR_W  = 20;   // center (Q12.8)
  localparam int INV_W  = 24;   // inverse radius (Q0.24)
  localparam int DIM_W  = 13;   // frame size
  localparam int SRC_W  = 21;   // source coordinate result

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Normalized radius squared saturates at 16.0 in Q.16.
  localparam int R2_W   = 21;
  localparam logic [R2_W-1:0] R2_MAX = R2_W'(1) << (R2_W - 1);

  typedef enum logic [2:0] {
    REG_K1     = 3'd0,
    REG_K2     = 3'd1,
    REG_CX     = 3'd2,
    REG_CY     = 3'd3,
    REG_INVR   = 3'd4,
    REG_WIDTH  = 3'd5,
    REG_HEIGHT = 3'd6
  } cfg_idx_t;

endpackage

// ----- rtl/radial_lens_warp_map.sv -----
// ----------------------------------------------------------------------------
// radial_lens_warp_map
// Per-pixel source address generator for a radial (Brown-Conrady) remap.
// ----------------------------------------------------------------------------
// Each request carries one output pixel (pixel_x, pixel_y) and produces one
// result: the distorted source position in unsigned Q12.8, rounded half up,
// or -1/-1 with in_range low when the source or the pixel falls outside the
// frame. The block is a nine-stage pipeline, so it takes a new request every
// clock while pix_stall is low and returns each result from its last stage
// register; a stalled output lets the stages behind it fill up before the
// request side is stalled. Registers are programmed over the APB port and
// must only be changed while no request is in flight.
module radial_lens_warp_map (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rlw_pkg::APB_AW-1:0]   paddr,
  input  logic [rlw_pkg::APB_DW-1:0]   pwdata,
  output logic [rlw_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         pix_valid,
  output logic                         pix_stall,
  input  logic [rlw_pkg::PIX_W-1:0]    pixel_x,
  input  logic [rlw_pkg::PIX_W-1:0]    pixel_y,
  output logic                         src_valid,
  input  logic                         src_stall,
  output logic signed [rlw_pkg::SRC_W-1:0] src_x_q8,
  output logic signed [rlw_pkg::SRC_W-1:0] src_y_q8,
  output logic                         in_range
);
  import rlw_pkg::*;

  localparam int NSTG  = 9;
  localparam int DX_W  = PIX_W + FRAC_BITS + 1;   // signed offset
  localparam int MAG_W = DX_W - 1;
  localparam int NSH   = FRAC_BITS + 8;            // normalize shift
  localparam int NP_W  = MAG_W + INV_W;
  localparam int AX_W  = NP_W - NSH;
  localparam int SQ_W  = 2 * AX_W;
  localparam int R4_W  = 2 * R2_W - 1 - 16;
  localparam int K1_W  = COEF_W + R2_W + 1;
  localparam int K2_W  = COEF_W + R4_W + 1;
  localparam int SC_W  = 48;
  localparam int SCL_W = SC_W - 16;
  localparam int PR_W  = DX_W + SCL_W;
  localparam int SX_W  = PR_W + 1;
  localparam int LSH   = FRAC_BITS + 16;

  // Configuration registers.
  logic signed [COEF_W-1:0] k1_coeff, k2_coeff;
  logic [CTR_W-1:0]         center_x, center_y;
  logic [INV_W-1:0]         inv_max_radius;
  logic [DIM_W-1:0]         image_width, image_height;

  cfg_idx_t cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_coeff       <= '0;
      k2_coeff       <= '0;
      center_x       <= '0;
      center_y       <= '0;
      inv_max_radius <= '0;
      image_width    <= DIM_W'(MAX_DIM);
      image_height   <= DIM_W'(MAX_DIM);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_K1:     k1_coeff       <= $signed(pwdata[COEF_W-1:0]);
        REG_K2:     k2_coeff       <= $signed(pwdata[COEF_W-1:0]);
        REG_CX:     center_x       <= pwdata[CTR_W-1:0];
        REG_CY:     center_y       <= pwdata[CTR_W-1:0];
        REG_INVR:   inv_max_radius <= pwdata[INV_W-1:0];
        REG_WIDTH:  image_width    <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height   <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_K1:     prdata = APB_DW'(unsigned'(k1_coeff));
      REG_K2:     prdata = APB_DW'(unsigned'(k2_coeff));
      REG_CX:     prdata = APB_DW'(center_x);
      REG_CY:     prdata = APB_DW'(center_y);
      REG_INVR:   prdata = APB_DW'(inv_max_radius);
      REG_WIDTH:  prdata = APB_DW'(image_width);
      REG_HEIGHT: prdata = APB_DW'(image_height);
      default:    prdata = '0;
    endcase
  end

  // Frame size clamped to the largest supported dimension.
  logic [DIM_W-1:0] frame_w, frame_h, frame_wm1, frame_hm1;
  assign frame_w   = (image_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width;
  assign frame_h   = (image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height;
  assign frame_wm1 = frame_w - DIM_W'(1);
  assign frame_hm1 = frame_h - DIM_W'(1);

  // Pipeline flow control: a stage may load when it is empty or the stage
  // after it is loading too.
  logic [NSTG-1:0] vld, en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || !src_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign pix_stall = !en[0];
  assign src_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= (i == 0) ? pix_valid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // Stage 1: offsets from the optical center and the frame check.
  logic signed [DX_W-1:0] s1_dx, s1_dy;
  logic                   s1_ok;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_dx <= $signed({1'b0, pixel_x, {FRAC_BITS{1'b0}}}) - $signed({1'b0, center_x});
      s1_dy <= $signed({1'b0, pixel_y, {FRAC_BITS{1'b0}}}) - $signed({1'b0, center_y});
      s1_ok <= (frame_w >= DIM_W'(2)) && (frame_h >= DIM_W'(2)) &&
               (DIM_W'(pixel_x) < frame_w) && (DIM_W'(pixel_y) < frame_h);
    end
  end

  // Stage 2: normalized magnitudes.
  logic [DX_W-1:0]        abs_x, abs_y;
  logic [NP_W-1:0]        nprod_x, nprod_y;
  logic [AX_W-1:0]        s2_ax, s2_ay;
  logic signed [DX_W-1:0] s2_dx, s2_dy;
  logic                   s2_ok;

  assign abs_x   = s1_dx[DX_W-1] ? DX_W'(-s1_dx) : DX_W'(s1_dx);
  assign abs_y   = s1_dy[DX_W-1] ? DX_W'(-s1_dy) : DX_W'(s1_dy);
  assign nprod_x = abs_x[MAG_W-1:0] * inv_max_radius;
  assign nprod_y = abs_y[MAG_W-1:0] * inv_max_radius;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_ax <= nprod_x[NP_W-1:NSH];
      s2_ay <= nprod_y[NP_W-1:NSH];
      s2_dx <= s1_dx;
      s2_dy <= s1_dy;
      s2_ok <= s1_ok;
    end
  end

  // Stage 3: squares.
  logic [SQ_W-1:0]        s3_sqx, s3_sqy;
  logic signed [DX_W-1:0] s3_dx, s3_dy;
  logic                   s3_ok;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_sqx <= s2_ax * s2_ax;
      s3_sqy <= s2_ay * s2_ay;
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;
      s3_ok  <= s2_ok;
    end
  end

  // Stage 4: radius squared in Q.16 with saturation.
  logic [SQ_W:0]          r2_sum;
  logic [SQ_W-16:0]       r2_full;
  logic [R2_W-1:0]        s4_r2;
  logic signed [DX_W-1:0] s4_dx, s4_dy;
  logic                   s4_ok;

  assign r2_sum  = {1'b0, s3_sqx} + {1'b0, s3_sqy};
  assign r2_full = r2_sum[SQ_W:16];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_r2 <= (r2_full > (SQ_W-15)'(R2_MAX)) ? R2_MAX : r2_full[R2_W-1:0];
      s4_dx <= s3_dx;
      s4_dy <= s3_dy;
      s4_ok <= s3_ok;
    end
  end

  // Stage 5: r^4 and the second-order term.
  logic [2*R2_W-1:0]       r4_full;
  logic [R4_W-1:0]         s5_r4;
  logic signed [K1_W-1:0]  s5_k1r2;
  logic signed [DX_W-1:0]  s5_dx, s5_dy;
  logic                    s5_ok;

  assign r4_full = s4_r2 * s4_r2;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_r4   <= r4_full[2*R2_W-2:16];
      s5_k1r2 <= k1_coeff * $signed({1'b0, s4_r2});
      s5_dx   <= s4_dx;
      s5_dy   <= s4_dy;
      s5_ok   <= s4_ok;
    end
  end

  // Stage 6: fourth-order term.
  logic signed [K2_W-1:0]  s6_k2r4;
  logic signed [K1_W-1:0]  s6_k1r2;
  logic signed [DX_W-1:0]  s6_dx, s6_dy;
  logic                    s6_ok;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_k2r4 <= k2_coeff * $signed({1'b0, s5_r4});
      s6_k1r2 <= s5_k1r2;
      s6_dx   <= s5_dx;
      s6_dy   <= s5_dy;
      s6_ok   <= s5_ok;
    end
  end

  // Stage 7: scale = 1 + k1*r2 + k2*r4, floored to Q.16.
  logic signed [SC_W-1:0]  scale32;
  logic signed [SCL_W-1:0] s7_scale;
  logic signed [DX_W-1:0]  s7_dx, s7_dy;
  logic                    s7_ok;

  assign scale32 = (SC_W'(1) <<< 32) + SC_W'(s6_k1r2) + SC_W'(s6_k2r4);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_scale <= scale32[SC_W-1:16];
      s7_dx    <= s6_dx;
      s7_dy    <= s6_dy;
      s7_ok    <= s6_ok;
    end
  end

  // Stage 8: scaled offsets.
  logic signed [PR_W-1:0] s8_px, s8_py;
  logic                   s8_ok;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_px <= s7_dx * s7_scale;
      s8_py <= s7_dy * s7_scale;
      s8_ok <= s7_ok;
    end
  end

  // Stage 9: add the center back, range check and round to Q.FRAC_BITS.
  logic signed [SX_W-1:0] sx, sy, lim_x, lim_y, rnd_x, rnd_y;
  logic                   src_ok;

  assign sx    = $signed({{(SX_W-CTR_W-16){1'b0}}, center_x, 16'd0}) + SX_W'(s8_px);
  assign sy    = $signed({{(SX_W-CTR_W-16){1'b0}}, center_y, 16'd0}) + SX_W'(s8_py);
  assign lim_x = $signed({{(SX_W-PIX_W-LSH){1'b0}}, frame_wm1[PIX_W-1:0], {LSH{1'b0}}});
  assign lim_y = $signed({{(SX_W-PIX_W-LSH){1'b0}}, frame_hm1[PIX_W-1:0], {LSH{1'b0}}});
  assign rnd_x = sx + (SX_W'(1) <<< 15);
  assign rnd_y = sy + (SX_W'(1) <<< 15);
  assign src_ok = s8_ok && !sx[SX_W-1] && !sy[SX_W-1] && (sx < lim_x) && (sy < lim_y);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      src_x_q8 <= src_ok ? $signed(rnd_x[SRC_W+15:16]) : '1;
      src_y_q8 <= src_ok ? $signed(rnd_y[SRC_W+15:16]) : '1;
      in_range <= src_ok;
    end
  end

endmodule

// ----- rtl/rlw_checker.sv -----
// ----------------------------------------------------------------------------
// rlw_checker
// Port-level checks for the radial lens warp map, bound to the top level.
// ----------------------------------------------------------------------------
module rlw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              src_valid,
  input logic                              src_stall,
  input logic signed [rlw_pkg::SRC_W-1:0]  src_x_q8,
  input logic signed [rlw_pkg::SRC_W-1:0]  src_y_q8,
  input logic                              in_range
);
  import rlw_pkg::*;

  // A result held by the receiver stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_x_q8) &&
                               $stable(src_y_q8) && $stable(in_range))
    else $error("stalled result changed");

  // An out-of-range result carries -1 in both coordinates.
  a_oor: assert property (@(posedge clk) disable iff (rst)
    src_valid && !in_range |-> (src_x_q8 == '1) && (src_y_q8 == '1))
    else $error("out-of-range result without -1 coordinates");

  // An in-range source is never negative.
  a_pos: assert property (@(posedge clk) disable iff (rst)
    src_valid && in_range |-> !src_x_q8[SRC_W-1] && !src_y_q8[SRC_W-1])
    else $error("in-range result with negative coordinate");

  // Reset empties the pipeline.
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !src_valid)
    else $error("result valid right after reset");

endmodule

bind radial_lens_warp_map rlw_checker u_rlw_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_x_q8  (src_x_q8),
  .src_y_q8  (src_y_q8),
  .in_range  (in_range)
);
